// ----- rtl/char_grid_fill_engine_top_assert.svh -----
// Assertion macros shared by the character grid fill engine modules.
// Included by the controller and the datapath; needs nothing else.
`ifndef CHAR_GRID_FILL_ENGINE_TOP_ASSERT_SVH
`define CHAR_GRID_FILL_ENGINE_TOP_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define CGFE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cgfe: same-cycle check failed");
// Next-cycle implication, checked outside reset.
`define CGFE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cgfe: next-cycle check failed");
`else
`define CGFE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CGFE_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/cgfe_pkg.sv -----
// Shared types and constants of the character grid fill engine.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cgfe_pkg;

    localparam int DEF_MAX_COLS = 64;
    localparam int DEF_MAX_ROWS = 64;

    localparam int CMD_W     = 3;
    localparam int COORD_W   = 6;
    localparam int DIM_W     = 7;
    localparam int CHAR_W    = 8;
    // Holds any linear address a box can reach: (63 + 126) * 127 + 63 + 126.
    localparam int ADDR_W    = 15;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 7;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ  = 3'd0,
        CMD_WRITE = 3'd1,
        CMD_ROW   = 3'd2,
        CMD_COL   = 3'd3,
        CMD_BOX   = 3'd4
    } t_cmd;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] GRID_DIM_RESET = 7'd64;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic setup;
        logic step;
        logic finish;
    } t_dp_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic walk_last;
        logic walk_empty;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- rtl/char_grid_fill_engine_top.sv -----
// Top level of the character grid fill engine: stream ports, field unpacking,
// controller and datapath. Depends on cgfe_pkg, cgfe_ctrl and cgfe_dp.
`timescale 1ns / 1ps
`default_nettype none

// Character grid fill engine. Holds a MAX_COLS x MAX_ROWS byte grid addressed
// linearly as row_y * grid_width + col_x, and takes one request at a time:
// read a cell, write a cell, fill a row, fill a column or fill a box. Cells at
// or beyond grid_width * grid_height are never written and set out_of_range.
// Each request passes through acceptance, a setup step for the address
// multiply, a walk over the N cells it addresses (1 for read and write,
// grid_width for a row, grid_height for a column, box_width * box_height for a
// box, and a single walk step for an empty box or an unknown command), and a
// step that loads the result register. The walk is set by the single port of
// the cell memory, which the address walker visits one cell per cycle. A result
// waiting on m_axis_tready stalls only the finish step of the following
// request. Reading a cell never written since reset returns an undefined byte.
// The user must write the grid size registers only while idle; the block does
// not enforce it.
module char_grid_fill_engine_top #(
    parameter int MAX_COLS = cgfe_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = cgfe_pkg::DEF_MAX_ROWS
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [cgfe_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [cgfe_pkg::CFG_W-1:0]          i_cfg_data,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // [2:0] cmd, [8:3] col_x, [14:9] row_y, [21:15] box_width,
    // [28:22] box_height, [36:29] fill_char, [39:37] zero
    input  wire  [cgfe_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // [7:0] read_char
    output logic [cgfe_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // [0] out_of_range
    output logic                                m_axis_tuser
);
    import cgfe_pkg::*;

    t_dp_ctl  w_ctl;
    t_dp_stat w_stat;

    cgfe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_ctl       (w_ctl),
        .i_stat      (w_stat)
    );

    cgfe_dp #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (s_axis_tdata[2:0]),
        .i_col_x        (s_axis_tdata[8:3]),
        .i_row_y        (s_axis_tdata[14:9]),
        .i_box_width    (s_axis_tdata[21:15]),
        .i_box_height   (s_axis_tdata[28:22]),
        .i_fill_char    (s_axis_tdata[36:29]),
        .i_ctl          (w_ctl),
        .o_stat         (w_stat),
        .o_read_char    (m_axis_tdata),
        .o_out_of_range (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ----- rtl/cgfe_ctrl.sv -----
// Sequencer of the character grid fill engine: accept, set up, walk cells, deliver.
// Depends on cgfe_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "char_grid_fill_engine_top_assert.svh"

module cgfe_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output cgfe_pkg::t_dp_ctl   o_ctl,
    input  cgfe_pkg::t_dp_stat  i_stat
);
    import cgfe_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_WALK,
        S_FINISH
    } t_state;

    t_state r_state;
    logic   r_out_valid;

    always_comb begin
        o_ctl         = '0;
        o_in_ready    = (r_state == S_IDLE);
        o_ctl.capture = (r_state == S_IDLE) && i_in_valid;
        o_ctl.setup   = (r_state == S_SETUP);
        o_ctl.step    = (r_state == S_WALK) && !i_stat.walk_empty;
        // The result register frees up in the same cycle the old result is taken.
        o_ctl.finish  = (r_state == S_FINISH) && (!r_out_valid || i_out_ready);
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_SETUP;
                end
                S_SETUP: begin
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    if (i_stat.walk_empty || i_stat.walk_last) r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (o_ctl.finish) r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (o_ctl.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `CGFE_ASSERT_NXT(a_accept_to_setup, i_clk, i_rst_n, o_ctl.capture, r_state == S_SETUP)
    `CGFE_ASSERT_NXT(a_finish_delivers, i_clk, i_rst_n, o_ctl.finish, r_out_valid && r_state == S_IDLE)
    `CGFE_ASSERT_IMP(a_step_only_walk, i_clk, i_rst_n, o_ctl.step, !o_in_ready && !o_ctl.finish)

endmodule

`default_nettype wire

// ----- rtl/cgfe_dp.sv -----
// Datapath of the character grid fill engine: grid registers, address walker,
// cell memory and result register. Depends on cgfe_pkg and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
`include "char_grid_fill_engine_top_assert.svh"

module cgfe_dp #(
    parameter int MAX_COLS = cgfe_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = cgfe_pkg::DEF_MAX_ROWS
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [cgfe_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [cgfe_pkg::CFG_W-1:0]       i_cfg_data,
    input  wire  [cgfe_pkg::CMD_W-1:0]       i_cmd,
    input  wire  [cgfe_pkg::COORD_W-1:0]     i_col_x,
    input  wire  [cgfe_pkg::COORD_W-1:0]     i_row_y,
    input  wire  [cgfe_pkg::DIM_W-1:0]       i_box_width,
    input  wire  [cgfe_pkg::DIM_W-1:0]       i_box_height,
    input  wire  [cgfe_pkg::CHAR_W-1:0]      i_fill_char,
    input  cgfe_pkg::t_dp_ctl                i_ctl,
    output cgfe_pkg::t_dp_stat               o_stat,
    output logic [cgfe_pkg::CHAR_W-1:0]      o_read_char,
    output logic                             o_out_of_range
);
    import cgfe_pkg::*;

    localparam int DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int MEM_AW = $clog2(DEPTH);

    logic [CFG_W-1:0]   r_grid_width;
    logic [CFG_W-1:0]   r_grid_height;
    logic [DIM_W-1:0]   w_eff_w;
    logic [DIM_W-1:0]   w_eff_h;

    logic [CMD_W-1:0]   r_cmd;
    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_y;
    logic [DIM_W-1:0]   r_bw;
    logic [DIM_W-1:0]   r_bh;
    logic [CHAR_W-1:0]  r_ch;

    logic [ADDR_W-1:0]  r_base;
    logic [ADDR_W-1:0]  r_limit;
    logic [DIM_W-1:0]   r_stride;
    logic [DIM_W-1:0]   r_rows;
    logic [DIM_W-1:0]   r_cols;
    logic [DIM_W-1:0]   r_row;
    logic [DIM_W-1:0]   r_col;
    logic               r_oor;

    logic [ADDR_W-1:0]  n_base;
    logic [DIM_W-1:0]   n_rows;
    logic [DIM_W-1:0]   n_cols;
    logic [COORD_W-1:0] w_start_x;
    logic [COORD_W-1:0] w_start_y;

    logic [ADDR_W-1:0]  w_addr;
    logic               w_in_range;
    logic               w_col_end;
    logic               w_we;
    logic [MEM_AW-1:0]  w_idx;

    logic [CHAR_W-1:0]  r_mem [DEPTH];
    logic [CHAR_W-1:0]  r_rdata;
    logic [CHAR_W-1:0]  r_read_char;
    logic               r_out_of_range;

    // Register values outside 1..MAX act as the nearest bound.
    always_comb begin
        if (r_grid_width == '0) begin
            w_eff_w = DIM_W'(1);
        end else if (int'(r_grid_width) > MAX_COLS) begin
            w_eff_w = DIM_W'(MAX_COLS);
        end else begin
            w_eff_w = r_grid_width;
        end
        if (r_grid_height == '0) begin
            w_eff_h = DIM_W'(1);
        end else if (int'(r_grid_height) > MAX_ROWS) begin
            w_eff_h = DIM_W'(MAX_ROWS);
        end else begin
            w_eff_h = r_grid_height;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= GRID_DIM_RESET;
            r_grid_height <= GRID_DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GRID_WIDTH:  r_grid_width  <= i_cfg_data;
                CFG_GRID_HEIGHT: r_grid_height <= i_cfg_data;
                default:         r_grid_width  <= r_grid_width;
            endcase
        end
    end

    // Every command becomes a rectangle walk: rows of cols cells, rows a stride apart.
    always_comb begin
        w_start_x = r_x;
        w_start_y = r_y;
        n_rows    = '0;
        n_cols    = '0;
        unique case (r_cmd)
            CMD_READ, CMD_WRITE: begin
                n_rows = DIM_W'(1);
                n_cols = DIM_W'(1);
            end
            CMD_ROW: begin
                w_start_x = '0;
                n_rows    = DIM_W'(1);
                n_cols    = w_eff_w;
            end
            CMD_COL: begin
                w_start_y = '0;
                n_rows    = w_eff_h;
                n_cols    = DIM_W'(1);
            end
            CMD_BOX: begin
                n_rows = r_bh;
                n_cols = r_bw;
            end
            default: begin
                n_rows = '0;
                n_cols = '0;
            end
        endcase
        n_base = ADDR_W'(w_start_y) * ADDR_W'(w_eff_w) + ADDR_W'(w_start_x);
    end

    assign w_addr     = r_base + ADDR_W'(r_col);
    assign w_in_range = (w_addr < r_limit);
    assign w_col_end  = (r_col == r_cols - DIM_W'(1));
    assign w_we       = i_ctl.step && w_in_range && (r_cmd != CMD_READ);
    assign w_idx      = MEM_AW'(w_addr);

    assign o_stat.walk_last  = w_col_end && (r_row == r_rows - DIM_W'(1));
    assign o_stat.walk_empty = (r_rows == '0) || (r_cols == '0);

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd <= i_cmd;
            r_x   <= i_col_x;
            r_y   <= i_row_y;
            r_bw  <= i_box_width;
            r_bh  <= i_box_height;
            r_ch  <= i_fill_char;
        end
        if (i_ctl.setup) begin
            r_base   <= n_base;
            r_limit  <= ADDR_W'(w_eff_w) * ADDR_W'(w_eff_h);
            r_stride <= w_eff_w;
            r_rows   <= n_rows;
            r_cols   <= n_cols;
            r_row    <= '0;
            r_col    <= '0;
            r_oor    <= 1'b0;
        end else if (i_ctl.step) begin
            if (!w_in_range) r_oor <= 1'b1;
            if (w_col_end) begin
                r_col  <= '0;
                r_row  <= r_row + DIM_W'(1);
                r_base <= r_base + ADDR_W'(r_stride);
            end else begin
                r_col <= r_col + DIM_W'(1);
            end
        end
        if (i_ctl.finish) begin
            r_read_char    <= ((r_cmd == CMD_READ) && !r_oor) ? r_rdata : '0;
            r_out_of_range <= r_oor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_idx] <= r_ch;
        end
        if (i_ctl.step) begin
            r_rdata <= r_mem[w_idx];
        end
    end

    assign o_read_char    = r_read_char;
    assign o_out_of_range = r_out_of_range;

    `CGFE_ASSERT_IMP(a_write_in_store, i_clk, i_rst_n, w_we, int'(w_addr) < DEPTH)
    `CGFE_ASSERT_IMP(a_walk_in_bounds, i_clk, i_rst_n, i_ctl.step, (r_col < r_cols) && (r_row < r_rows))
    `CGFE_ASSERT_NXT(a_setup_clears_flag, i_clk, i_rst_n, i_ctl.setup, !r_oor && r_col == '0 && r_row == '0)

endmodule

`default_nettype wire

// ----- tb/char_grid_fill_engine_top_tb.sv -----
// Self-checking testbench for the character grid fill engine top level.
// Drives directed and random requests, predicts results from a shadow grid unless typed in.
// Depends on cgfe_pkg and char_grid_fill_engine_top.
`timescale 1ns / 1ps

module char_grid_fill_engine_top_tb;
    import cgfe_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;
    localparam int GRID_CELLS = DEF_MAX_COLS * DEF_MAX_ROWS;
    localparam int PHASES = 9;
    localparam int PHASE_ITEMS = 55;

    // Command codes the block treats as no-ops.
    localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

    // Field order matches s_axis_tdata from the highest bit down.
    typedef struct packed {
        logic [CHAR_W-1:0]  fill_char;
        logic [DIM_W-1:0]   box_height;
        logic [DIM_W-1:0]   box_width;
        logic [COORD_W-1:0] row_y;
        logic [COORD_W-1:0] col_x;
        logic [CMD_W-1:0]   cmd;
    } t_grid_req;

    typedef struct packed {
        logic [CHAR_W-1:0] read_char;
        logic              out_of_range;
    } t_grid_result;

    typedef struct {
        bit           is_cfg;
        logic [CFG_W-1:0] cfg_w;
        logic [CFG_W-1:0] cfg_h;
        t_grid_req    req;
        bit           typed;
        t_grid_result want;
    } t_dir_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_W-1:0]       i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    // Shadow of the grid and of the size registers.
    logic [CHAR_W-1:0] grid_mem [GRID_CELLS];
    bit                cell_written [GRID_CELLS];
    logic [CFG_W-1:0]  cfg_width = GRID_DIM_RESET;
    logic [CFG_W-1:0]  cfg_height = GRID_DIM_RESET;

    t_grid_result pending_results [$];
    int  mismatch_count = 0;
    int  cycle_count = 0;
    bit  quiet_mode = 1'b0;
    bit  hold_request = 1'b0;

    char_grid_fill_engine_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int eff_dim(logic [CFG_W-1:0] v, int max_dim);
        if (v == 0) return 1;
        if (int'(v) > max_dim) return max_dim;
        return int'(v);
    endfunction

    // Mostly short idle stretches, now and then a long one.
    function automatic int pick_idle();
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(input string field, input int want, input int got);
        $display("MISMATCH %s: expected %0d, got %0d at cycle %0d", field, want, got,
                 cycle_count);
        mismatch_count++;
    endtask

    task automatic store_cell(input int addr, input int lim, input logic [CHAR_W-1:0] ch,
                              inout logic oor);
        if (addr >= lim) begin
            oor = 1'b1;
        end else begin
            grid_mem[addr] = ch;
            cell_written[addr] = 1'b1;
        end
    endtask

    task automatic predict_grid_request(input t_grid_req rq, output t_grid_result res);
        int w;
        int h;
        int lim;
        int addr;
        w = eff_dim(cfg_width, DEF_MAX_COLS);
        h = eff_dim(cfg_height, DEF_MAX_ROWS);
        lim = w * h;
        res = '0;
        case (rq.cmd)
            CMD_READ: begin
                addr = rq.row_y * w + rq.col_x;
                if (addr >= lim) res.out_of_range = 1'b1;
                else res.read_char = grid_mem[addr];
            end
            CMD_WRITE: begin
                store_cell(rq.row_y * w + rq.col_x, lim, rq.fill_char, res.out_of_range);
            end
            CMD_ROW: begin
                for (int i = 0; i < w; i++)
                    store_cell(rq.row_y * w + i, lim, rq.fill_char, res.out_of_range);
            end
            CMD_COL: begin
                for (int i = 0; i < h; i++)
                    store_cell(i * w + rq.col_x, lim, rq.fill_char, res.out_of_range);
            end
            CMD_BOX: begin
                // Box rows wrap linearly into the next grid row.
                for (int i = 0; i < rq.box_height; i++)
                    for (int j = 0; j < rq.box_width; j++)
                        store_cell((rq.row_y + i) * w + rq.col_x + j, lim, rq.fill_char,
                                   res.out_of_range);
            end
            default: ;
        endcase
    endtask

    task automatic send_grid_request(input t_grid_req rq, input bit typed,
                                     input t_grid_result want);
        t_grid_result pred;
        int gap;
        gap = (!quiet_mode && $urandom_range(0, 2) == 0) ? pick_idle() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(rq);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_grid_request(rq, pred);
        pending_results.push_back(typed ? want : pred);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_grid_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_GRID_WIDTH;
        i_cfg_data  <= w;
        @(negedge i_clk);
        i_cfg_index <= CFG_GRID_HEIGHT;
        i_cfg_data  <= h;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_width  = w;
        cfg_height = h;
    endtask

    function automatic t_dir_row mk_req(logic [CMD_W-1:0] c, int x, int y, int bw, int bh,
                                        int ch, bit typed, int rd, bit oor);
        t_dir_row row;
        row.is_cfg = 1'b0;
        row.cfg_w = '0;
        row.cfg_h = '0;
        row.req.cmd = c;
        row.req.col_x = x[COORD_W-1:0];
        row.req.row_y = y[COORD_W-1:0];
        row.req.box_width = bw[DIM_W-1:0];
        row.req.box_height = bh[DIM_W-1:0];
        row.req.fill_char = ch[CHAR_W-1:0];
        row.typed = typed;
        row.want.read_char = rd[CHAR_W-1:0];
        row.want.out_of_range = oor;
        return row;
    endfunction

    function automatic t_dir_row mk_cfg(int w, int h);
        t_dir_row row;
        row = mk_req(CMD_READ, 0, 0, 0, 0, 0, 1'b0, 0, 1'b0);
        row.is_cfg = 1'b1;
        row.cfg_w = w[CFG_W-1:0];
        row.cfg_h = h[CFG_W-1:0];
        return row;
    endfunction

    task automatic random_grid_request(output t_grid_req rq);
        int w;
        int h;
        int r;
        int addr;
        w = eff_dim(cfg_width, DEF_MAX_COLS);
        h = eff_dim(cfg_height, DEF_MAX_ROWS);
        r = $urandom_range(0, 99);
        if (r < 30) rq.cmd = CMD_READ;
        else if (r < 52) rq.cmd = CMD_WRITE;
        else if (r < 62) rq.cmd = CMD_ROW;
        else if (r < 72) rq.cmd = CMD_COL;
        else if (r < 94) rq.cmd = CMD_BOX;
        else begin
            case ($urandom_range(0, 2))
                0: rq.cmd = CMD_RSVD5;
                1: rq.cmd = CMD_RSVD6;
                default: rq.cmd = CMD_RSVD7;
            endcase
        end
        if ($urandom_range(0, 9) < 7) begin
            rq.col_x = COORD_W'($urandom_range(0, w - 1));
            rq.row_y = COORD_W'($urandom_range(0, h - 1));
        end else begin
            rq.col_x = COORD_W'($urandom_range(0, 63));
            rq.row_y = COORD_W'($urandom_range(0, 63));
        end
        // Large boxes cost one cycle per cell, so they stay rare.
        if (rq.cmd != CMD_BOX || $urandom_range(0, 49) == 0) begin
            rq.box_width  = DIM_W'($urandom_range(0, 64));
            rq.box_height = DIM_W'($urandom_range(0, 64));
        end else begin
            rq.box_width  = DIM_W'($urandom_range(0, 6));
            rq.box_height = DIM_W'($urandom_range(0, 6));
        end
        rq.fill_char = CHAR_W'($urandom_range(0, 255));
        // A cell that was never written must not be read back.
        addr = rq.row_y * w + rq.col_x;
        if (rq.cmd == CMD_READ && addr < w * h && !cell_written[addr]) rq.cmd = CMD_WRITE;
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        t_grid_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, read_char", -1, int'(m_axis_tdata));
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata !== want.read_char)
                    report_mismatch("read_char", int'(want.read_char), int'(m_axis_tdata));
                if (m_axis_tuser !== want.out_of_range)
                    report_mismatch("out_of_range", int'(want.out_of_range),
                                    int'(m_axis_tuser));
            end
        end
    end

    // Result side back-pressure, plus the long hold-off on request.
    initial begin
        int stall_left;
        stall_left = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && !quiet_mode && $urandom_range(0, 9) == 0) begin
                stall_left = pick_idle();
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        t_dir_row     dir_rows [$];
        t_grid_req    rq;
        t_grid_result none;
        logic [CFG_W-1:0] pw;
        logic [CFG_W-1:0] ph;

        none = '0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_GRID_WIDTH;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table; expected results are typed in where they are obvious.
        dir_rows.push_back(mk_req(CMD_BOX,   0,  0, 64, 64, 8'h20, 1, 8'h20 & 0, 0));
        dir_rows.push_back(mk_req(CMD_READ,  0,  0,  0,  0, 8'h00, 1, 8'h20, 0));
        dir_rows.push_back(mk_req(CMD_READ, 63, 63, 64, 64, 8'hFF, 1, 8'h20, 0));
        dir_rows.push_back(mk_req(CMD_WRITE, 63, 63, 0, 0, 8'hFF, 1, 0, 0));
        dir_rows.push_back(mk_req(CMD_READ, 63, 63,  0,  0, 8'h00, 1, 8'hFF, 0));
        dir_rows.push_back(mk_req(CMD_WRITE, 0,  0,  0,  0, 8'h00, 1, 0, 0));
        dir_rows.push_back(mk_req(CMD_READ,  0,  0,  0,  0, 8'h00, 1, 8'h00, 0));
        dir_rows.push_back(mk_req(CMD_ROW,   0, 63,  0,  0, 8'hA5, 1, 0, 0));
        dir_rows.push_back(mk_req(CMD_COL,   0,  0,  0,  0, 8'h5A, 1, 0, 0));
        dir_rows.push_back(mk_req(CMD_READ,  0, 63,  0,  0, 8'h00, 0, 0, 0));
        // Box partly past the last cell: in-range cells written, flag raised.
        dir_rows.push_back(mk_req(CMD_BOX,  62, 63,  4,  1, 8'h77, 1, 0, 1));
        dir_rows.push_back(mk_req(CMD_READ, 62, 63,  0,  0, 8'h00, 0, 0, 0));
        dir_rows.push_back(mk_req(CMD_BOX,  10, 10,  0,  5, 8'h99, 1, 0, 0));
        dir_rows.push_back(mk_req(CMD_BOX,  10, 10,  5,  0, 8'h99, 1, 0, 0));
        // Box row running past the right edge wraps into the next row.
        dir_rows.push_back(mk_req(CMD_BOX,  60,  0,  8,  2, 8'h33, 0, 0, 0));
        dir_rows.push_back(mk_req(CMD_READ,  0,  1,  0,  0, 8'h00, 0, 0, 0));
        dir_rows.push_back(mk_req(CMD_RSVD7, 63, 63, 64, 64, 8'hFF, 1, 0, 0));
        dir_rows.push_back(mk_req(CMD_BOX,  63, 63, 64, 64, 8'hC3, 1, 0, 1));
        dir_rows.push_back(mk_req(CMD_READ, 63, 63,  0,  0, 8'h00, 0, 0, 0));
        dir_rows.push_back(mk_cfg(1, 1));
        dir_rows.push_back(mk_req(CMD_READ,  5,  0,  0,  0, 8'h00, 1, 0, 1));
        dir_rows.push_back(mk_req(CMD_WRITE, 0,  0,  0,  0, 8'h11, 1, 0, 0));
        dir_rows.push_back(mk_req(CMD_READ,  0,  0,  0,  0, 8'h00, 0, 0, 0));
        // Zero width acts as one and an oversized height saturates.
        dir_rows.push_back(mk_cfg(0, 127));
        dir_rows.push_back(mk_req(CMD_COL,   0,  0,  0,  0, 8'h44, 1, 0, 0));
        dir_rows.push_back(mk_req(CMD_COL,   1,  0,  0,  0, 8'h45, 1, 0, 1));
        dir_rows.push_back(mk_req(CMD_ROW,   0, 63,  0,  0, 8'h46, 1, 0, 0));
        dir_rows.push_back(mk_cfg(64, 64));

        foreach (dir_rows[n]) begin
            if (dir_rows[n].is_cfg) begin
                drain_results();
                write_grid_size(dir_rows[n].cfg_w, dir_rows[n].cfg_h);
            end else begin
                send_grid_request(dir_rows[n].req, dir_rows[n].typed, dir_rows[n].want);
            end
        end
        drain_results();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin pw = CFG_W'(64);  ph = CFG_W'(64);  end
                1: begin pw = CFG_W'(1);   ph = CFG_W'(1);   end
                2: begin pw = CFG_W'(0);   ph = CFG_W'(0);   end
                3: begin pw = CFG_W'(127); ph = CFG_W'(127); end
                4: begin pw = CFG_W'(64);  ph = CFG_W'(1);   end
                5: begin pw = CFG_W'(1);   ph = CFG_W'(64);  end
                6: begin
                    pw = CFG_W'($urandom_range(1, 64));
                    ph = CFG_W'($urandom_range(1, 64));
                end
                7: begin
                    pw = CFG_W'($urandom_range(0, 127));
                    ph = CFG_W'($urandom_range(0, 127));
                end
                default: begin pw = CFG_W'(33); ph = CFG_W'(17); end
            endcase
            write_grid_size(pw, ph);
            quiet_mode = (p == 3 || p == 6);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                random_grid_request(rq);
                send_grid_request(rq, 1'b0, none);
                // Long result stall while requests keep coming.
                if ((p == 0 || p == 3) && k == 5) hold_request = 1'b1;
                // Sender pause until everything outstanding has come back.
                if (p == 4 && k == 20) drain_results();
            end
            drain_results();
        end
        quiet_mode = 1'b0;

        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
